### rtl/core/iurc_pkg.sv
// ----------------------------------------------------------------------------
// iurc_pkg: image update receive controller shared definitions
// Item types, command and status codes, sizes and the per-byte CRC-32 step.
// ----------------------------------------------------------------------------
package iurc_pkg;

  // Field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned SizeW   = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StateW  = 3;
  localparam int unsigned ErrW    = 4;
  localparam int unsigned PctW    = 7;
  localparam int unsigned CrcW    = 32;
  localparam int unsigned TimerW  = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;

  // Chunk length saturates one above the largest chunk
  localparam int unsigned MaxChunk  = 512;
  localparam int unsigned ChunkLenW = $clog2(MaxChunk + 2);

  // Percent division: dividend is received bytes times 100
  localparam int unsigned DivW    = SizeW + PctW;
  localparam int unsigned DivCntW = $clog2(PctW);

  localparam logic [PctW-1:0]   Hundred  = PctW'(100);
  localparam logic [CrcW-1:0]   CrcInit  = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0]   CrcPoly  = 32'hEDB8_8320;
  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

  // Reset values of the configuration registers
  localparam logic [SizeW-1:0]  MaxImageRst = SizeW'(1572864);
  localparam logic [TimerW-1:0] GlobalToRst = TimerW'(300000);
  localparam logic [TimerW-1:0] WaitToRst   = TimerW'(30000);
  localparam logic [TimerW-1:0] ChunkToRst  = TimerW'(10000);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_IMAGE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GLOBAL_TO  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WAITING_TO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_CHUNK_TO   = 2'd3;

  // Commands
  localparam logic [OpW-1:0] OP_START  = 3'd0;
  localparam logic [OpW-1:0] OP_ABORT  = 3'd1;
  localparam logic [OpW-1:0] OP_VERIFY = 3'd2;
  localparam logic [OpW-1:0] OP_DATA   = 3'd3;
  localparam logic [OpW-1:0] OP_TICK   = 3'd4;

  // Session states
  localparam logic [StateW-1:0] SES_IDLE      = 3'd0;
  localparam logic [StateW-1:0] SES_WAITING   = 3'd1;
  localparam logic [StateW-1:0] SES_RECEIVING = 3'd2;
  localparam logic [StateW-1:0] SES_VERIFYING = 3'd3;
  localparam logic [StateW-1:0] SES_READY     = 3'd4;
  localparam logic [StateW-1:0] SES_ERROR     = 3'd5;

  // Error codes
  localparam logic [ErrW-1:0] ERR_NONE       = 4'd0;
  localparam logic [ErrW-1:0] ERR_BUSY       = 4'd1;
  localparam logic [ErrW-1:0] ERR_BAD_SIZE   = 4'd2;
  localparam logic [ErrW-1:0] ERR_BEGIN      = 4'd3;
  localparam logic [ErrW-1:0] ERR_NOT_RX     = 4'd4;
  localparam logic [ErrW-1:0] ERR_FINISH     = 4'd5;
  localparam logic [ErrW-1:0] ERR_OVERFLOW   = 4'd6;
  localparam logic [ErrW-1:0] ERR_WRITE      = 4'd7;
  localparam logic [ErrW-1:0] ERR_OVERSIZE   = 4'd8;
  localparam logic [ErrW-1:0] ERR_GLOBAL_TO  = 4'd9;
  localparam logic [ErrW-1:0] ERR_WAITING_TO = 4'd10;
  localparam logic [ErrW-1:0] ERR_CHUNK_TO   = 4'd11;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [SizeW-1:0] size;
    logic [ByteW-1:0] data_byte;
    logic             chunk_last;
    logic             begin_fail;
    logic             write_fail;
    logic             finish_fail;
  } iurc_in_t;

  typedef struct packed {
    logic [StateW-1:0] session_state;
    logic [ErrW-1:0]   error_code;
    logic [SizeW-1:0]  received_bytes;
    logic [SizeW-1:0]  total_bytes;
    logic [PctW-1:0]   progress_percent;
    logic [CrcW-1:0]   image_crc;
  } iurc_out_t;

  // Divider handshake towards the sequencer
  typedef struct packed {
    logic            done;
    logic [PctW-1:0] quot;
  } iurc_div_rsp_t;

  // Reflected CRC-32 over one byte, an XOR network of eight bit steps
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc_in ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int i = 0; i < ByteW; i++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : '0);
    end
    return c;
  endfunction

endpackage

### rtl/core/image_update_receive_controller_core.sv
// ----------------------------------------------------------------------------
// image_update_receive_controller_core: firmware image receive controller
// Session control, chunk CRC, timeouts and progress percent of an update.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one command item: start,
//   abort, verify, data byte or millisecond tick. Output channel out_valid_o /
//   out_stall_i returns exactly one status item per command, showing the
//   session after it. Configuration registers (maximum image size and the
//   three timeouts) are written through cfg_we_i / cfg_index_i / cfg_data_i;
//   write them only while no command is in flight (not enforced by the block).
//   Sequence: a command is decoded the cycle after it is taken and its status
//   item is then loaded into the output register; a data byte that closes and
//   commits a chunk first passes through the percent divider (one start state,
//   seven quotient bits and the handover of the quotient). A new command is
//   taken once the previous one has been handed to the output register; the
//   sequencer and the bit-serial divider work on one command at a time.
//   Reset puts the session idle with all counters cleared and the
//   configuration registers at their defaults. If the receiver stalls, the
//   status item waits in the output register; one further command can be
//   processed, then the block stalls its input until the output drains.
// ----------------------------------------------------------------------------
module image_update_receive_controller_core import iurc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  iurc_in_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output iurc_out_t          out_item_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  // Sequencer codes
  localparam logic [2:0] SQ_IDLE = 3'd0;
  localparam logic [2:0] SQ_EXEC = 3'd1;
  localparam logic [2:0] SQ_MUL  = 3'd2;
  localparam logic [2:0] SQ_DIV  = 3'd3;
  localparam logic [2:0] SQ_OUT  = 3'd4;

  logic [2:0] seq_q, seq_d;

  // Configuration
  logic [SizeW-1:0]  max_img_q;
  logic [TimerW-1:0] global_to_q, wait_to_q, chunk_to_q;

  // Latched command
  iurc_in_t cmd_q;

  // Session state
  logic [StateW-1:0]    ses_q, ses_d;
  logic [ErrW-1:0]      err_q, err_d;
  logic [SizeW-1:0]     total_q, total_d;
  logic [SizeW-1:0]     recv_q, recv_d;
  logic [CrcW-1:0]      acc_q, acc_d;
  logic [CrcW-1:0]      ccrc_q, ccrc_d;
  logic [ChunkLenW-1:0] clen_q, clen_d;
  logic [TimerW-1:0]    sstart_q, sstart_d;
  logic [TimerW-1:0]    schunk_q, schunk_d;
  logic [PctW-1:0]      pct_q, pct_d;
  logic                 need_pct;

  // Working values of the command decode
  logic                 clr, load_total;
  logic [CrcW-1:0]      crc_b;
  logic [ChunkLenW-1:0] len_inc;
  logic [SizeW:0]       sum;
  logic [TimerW-1:0]    ss_inc, sc_inc;

  // Divider
  logic          div_start;
  logic [DivW-1:0] dividend;
  iurc_div_rsp_t div_rsp;

  // Output register
  logic      out_valid_q;
  iurc_out_t out_item_q;
  logic      out_ld;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_img_q   <= MaxImageRst;
      global_to_q <= GlobalToRst;
      wait_to_q   <= WaitToRst;
      chunk_to_q  <= ChunkToRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_IMAGE:  max_img_q   <= cfg_data_i[SizeW-1:0];
        CFG_GLOBAL_TO:  global_to_q <= cfg_data_i[TimerW-1:0];
        CFG_WAITING_TO: wait_to_q   <= cfg_data_i[TimerW-1:0];
        CFG_CHUNK_TO:   chunk_to_q  <= cfg_data_i[TimerW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (seq_q != SQ_IDLE);

  // Command decode, evaluated in the execute cycle
  always_comb begin
    ses_d      = ses_q;
    err_d      = err_q;
    total_d    = total_q;
    recv_d     = recv_q;
    acc_d      = acc_q;
    ccrc_d     = ccrc_q;
    clen_d     = clen_q;
    sstart_d   = sstart_q;
    schunk_d   = schunk_q;
    pct_d      = pct_q;
    need_pct   = 1'b0;
    clr        = 1'b0;
    load_total = 1'b0;
    crc_b      = crc_byte(ccrc_q, cmd_q.data_byte);
    len_inc    = (clen_q <= ChunkLenW'(MaxChunk)) ? clen_q + 1'b1 : clen_q;
    sum        = {1'b0, recv_q} + (SizeW+1)'(len_inc);
    ss_inc     = (sstart_q != TimerMax) ? sstart_q + 1'b1 : sstart_q;
    sc_inc     = (schunk_q != TimerMax) ? schunk_q + 1'b1 : schunk_q;

    case (cmd_q.op)
      OP_START: begin
        if (ses_q != SES_IDLE && ses_q != SES_ERROR) begin
          ses_d = SES_ERROR;
          err_d = ERR_BUSY;
        end else if (cmd_q.size == '0 || cmd_q.size > max_img_q) begin
          ses_d = SES_ERROR;
          err_d = ERR_BAD_SIZE;
        end else if (cmd_q.begin_fail) begin
          ses_d = SES_ERROR;
          err_d = ERR_BEGIN;
        end else begin
          clr        = 1'b1;
          load_total = 1'b1;
          err_d      = ERR_NONE;
          ses_d      = SES_WAITING;
        end
      end
      OP_ABORT: begin
        clr   = 1'b1;
        ses_d = SES_IDLE;
        err_d = ERR_NONE;
      end
      OP_VERIFY: begin
        if (ses_q != SES_RECEIVING) begin
          ses_d = SES_ERROR;
          err_d = ERR_NOT_RX;
        end else if (cmd_q.finish_fail) begin
          ses_d = SES_ERROR;
          err_d = ERR_FINISH;
        end else begin
          ses_d = SES_READY;
        end
      end
      OP_DATA: begin
        if (ses_q == SES_WAITING || ses_q == SES_RECEIVING) begin
          ccrc_d = crc_b;
          clen_d = len_inc;
          if (cmd_q.chunk_last) begin
            // Chunk end: checks in priority order, then commit
            clen_d = '0;
            ses_d  = SES_RECEIVING;
            if (len_inc > ChunkLenW'(MaxChunk)) begin
              clr   = 1'b1;
              ses_d = SES_IDLE;
              err_d = ERR_OVERSIZE;
            end else if (sum > {1'b0, total_q}) begin
              clr   = 1'b1;
              ses_d = SES_IDLE;
              err_d = ERR_OVERFLOW;
            end else if (cmd_q.write_fail) begin
              clr   = 1'b1;
              ses_d = SES_IDLE;
              err_d = ERR_WRITE;
            end else begin
              recv_d   = sum[SizeW-1:0];
              schunk_d = '0;
              acc_d    = acc_q ^ ~crc_b;
              ccrc_d   = CrcInit;
              if (total_q != '0) begin
                need_pct = 1'b1;
              end else begin
                pct_d = '0;
              end
              // Complete image verifies at once
              if (sum >= {1'b0, total_q}) begin
                if (cmd_q.finish_fail) begin
                  ses_d = SES_ERROR;
                  err_d = ERR_FINISH;
                end else begin
                  ses_d = SES_READY;
                end
              end
            end
          end
        end
      end
      OP_TICK: begin
        sstart_d = ss_inc;
        schunk_d = sc_inc;
        if (ses_q != SES_IDLE && ses_q != SES_ERROR && ss_inc > global_to_q) begin
          clr   = 1'b1;
          ses_d = SES_IDLE;
          err_d = ERR_GLOBAL_TO;
        end else if (ses_q == SES_WAITING && ss_inc > wait_to_q) begin
          clr   = 1'b1;
          ses_d = SES_IDLE;
          err_d = ERR_WAITING_TO;
        end else if (ses_q == SES_RECEIVING && sc_inc > chunk_to_q) begin
          clr   = 1'b1;
          ses_d = SES_IDLE;
          err_d = ERR_CHUNK_TO;
        end
      end
      default: ;
    endcase

    // Session clear, with the new size on a good start
    if (clr) begin
      total_d  = load_total ? cmd_q.size : '0;
      recv_d   = '0;
      acc_d    = '0;
      pct_d    = '0;
      sstart_d = '0;
      schunk_d = '0;
      ccrc_d   = CrcInit;
      clen_d   = '0;
    end

    // Chunk accumulator only lives while a transfer is open
    if (ses_d != SES_WAITING && ses_d != SES_RECEIVING) begin
      ccrc_d = CrcInit;
      clen_d = '0;
    end
  end

  // Sequencer
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SQ_IDLE: if (in_valid_i) seq_d = SQ_EXEC;
      SQ_EXEC: seq_d = need_pct ? SQ_MUL : SQ_OUT;
      SQ_MUL:  seq_d = SQ_DIV;
      SQ_DIV:  if (div_rsp.done) seq_d = SQ_OUT;
      SQ_OUT:  if (out_ld) seq_d = SQ_IDLE;
      default: seq_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= SQ_IDLE;
      ses_q    <= SES_IDLE;
      err_q    <= ERR_NONE;
      total_q  <= '0;
      recv_q   <= '0;
      acc_q    <= '0;
      ccrc_q   <= CrcInit;
      clen_q   <= '0;
      sstart_q <= '0;
      schunk_q <= '0;
      pct_q    <= '0;
    end else begin
      seq_q <= seq_d;
      if (seq_q == SQ_EXEC) begin
        ses_q    <= ses_d;
        err_q    <= err_d;
        total_q  <= total_d;
        recv_q   <= recv_d;
        acc_q    <= acc_d;
        ccrc_q   <= ccrc_d;
        clen_q   <= clen_d;
        sstart_q <= sstart_d;
        schunk_q <= schunk_d;
        pct_q    <= pct_d;
      end else if (seq_q == SQ_DIV && div_rsp.done) begin
        pct_q <= div_rsp.quot;
      end
    end
  end

  // Command capture
  always_ff @(posedge clk_i) begin
    if (seq_q == SQ_IDLE && in_valid_i) begin
      cmd_q <= in_item_i;
    end
  end

  // Percent: received times 100, then divided by the total
  assign div_start = (seq_q == SQ_MUL);
  assign dividend  = DivW'(recv_q) * DivW'(Hundred);

  iurc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (total_q),
    .rsp_o      (div_rsp)
  );

  // Output register
  assign out_ld = (seq_q == SQ_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_item_q.session_state    <= ses_q;
      out_item_q.error_code       <= err_q;
      out_item_q.received_bytes   <= recv_q;
      out_item_q.total_bytes      <= total_q;
      out_item_q.progress_percent <= pct_q;
      out_item_q.image_crc        <= acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> seq_q == SQ_EXEC)
    else $error("accepted item not decoded next cycle");

  a_recv_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recv_q <= total_q)
    else $error("received count exceeds image size");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pct_q <= Hundred)
    else $error("progress above 100 percent");

  a_div_done_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> seq_q == SQ_DIV)
    else $error("divider result outside divide phase");

endmodule

### rtl/core/iurc_div.sv
// ----------------------------------------------------------------------------
// iurc_div: iterative percent divider
// Restoring division, one quotient bit per cycle, quotient below 128.
// ----------------------------------------------------------------------------
module iurc_div import iurc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivW-1:0]  dividend_i,
  input  logic [SizeW-1:0] divisor_i,
  output iurc_div_rsp_t    rsp_o
);

  logic [DivW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    dsh_q, dsh_d;
  logic [PctW-1:0]    quot_q, quot_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               fits;

  // Trial subtract of the shifted divisor
  assign fits = (rem_q >= dsh_q);

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dsh_d  = DivW'({divisor_i, {(PctW-1){1'b0}}});
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[PctW-2:0], fits};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(PctW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### tb/sv/tb_image_update_receive_controller_core.sv
// ----------------------------------------------------------------------------
// tb_image_update_receive_controller_core: self-checking bench for the core
// Drives command items through a queue-fed driver and checks every status
// item against an in-bench model of the session, CRC, timers and percent.
// Runs several configuration and pacing phases, including a long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_image_update_receive_controller_core import iurc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  iurc_in_t           in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  iurc_out_t          out_item;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  // Pacing and bookkeeping
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_on = 1'b0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  iurc_in_t  cmd_q[$];
  iurc_out_t status_q[$];

  // Model copy of the configuration
  logic [SizeW-1:0]  cfg_max_image;
  logic [TimerW-1:0] cfg_global_to;
  logic [TimerW-1:0] cfg_waiting_to;
  logic [TimerW-1:0] cfg_chunk_to;

  // Model copy of the session state
  logic [StateW-1:0]    st_fsm;
  logic [ErrW-1:0]      st_err;
  logic [SizeW-1:0]     st_total;
  logic [SizeW-1:0]     st_received;
  logic [CrcW-1:0]      st_crc_acc;
  logic [CrcW-1:0]      st_chunk_crc;
  logic [ChunkLenW-1:0] st_chunk_len;
  logic [TimerW-1:0]    st_since_start;
  logic [TimerW-1:0]    st_since_chunk;
  logic [PctW-1:0]      st_percent;

  image_update_receive_controller_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model
  function automatic void model_clear();
    st_total       = '0;
    st_received    = '0;
    st_crc_acc     = '0;
    st_percent     = '0;
    st_since_start = '0;
    st_since_chunk = '0;
    st_chunk_crc   = CrcInit;
    st_chunk_len   = '0;
  endfunction

  function automatic void model_abort(input logic [ErrW-1:0] code);
    model_clear();
    st_fsm = SES_IDLE;
    st_err = code;
  endfunction

  function automatic void model_fail(input logic [ErrW-1:0] code);
    st_fsm = SES_ERROR;
    st_err = code;
  endfunction

  function automatic void model_verify(input logic finish_fail);
    if (st_fsm != SES_RECEIVING) model_fail(ERR_NOT_RX);
    else if (finish_fail) model_fail(ERR_FINISH);
    else st_fsm = SES_READY;
  endfunction

  // Advances the session by one command and returns the status it shows
  function automatic iurc_out_t session_step(input iurc_in_t c);
    iurc_out_t            r;
    logic [CrcW-1:0]      crc;
    logic                 fb;
    logic [ChunkLenW-1:0] len;
    logic [SizeW:0]       sum;
    case (c.op)
      OP_START: begin
        if (st_fsm != SES_IDLE && st_fsm != SES_ERROR) model_fail(ERR_BUSY);
        else if (c.size == '0 || c.size > cfg_max_image) model_fail(ERR_BAD_SIZE);
        else if (c.begin_fail) model_fail(ERR_BEGIN);
        else begin
          model_clear();
          st_total = c.size;
          st_err   = ERR_NONE;
          st_fsm   = SES_WAITING;
        end
      end
      OP_ABORT:  model_abort(ERR_NONE);
      OP_VERIFY: model_verify(c.finish_fail);
      OP_DATA: begin
        if (st_fsm == SES_WAITING || st_fsm == SES_RECEIVING) begin
          // reflected CRC-32, one bit at a time, LSB first
          crc = st_chunk_crc;
          for (int k = 0; k < ByteW; k++) begin
            fb  = crc[0] ^ c.data_byte[k];
            crc = {1'b0, crc[CrcW-1:1]} ^ (fb ? CrcPoly : '0);
          end
          st_chunk_crc = crc;
          if (st_chunk_len <= MaxChunk) st_chunk_len = st_chunk_len + 1'b1;
          if (c.chunk_last) begin
            len          = st_chunk_len;
            st_chunk_len = '0;
            st_fsm       = SES_RECEIVING;
            sum          = {1'b0, st_received} + (SizeW+1)'(len);
            if (len > MaxChunk) model_abort(ERR_OVERSIZE);
            else if (sum > {1'b0, st_total}) model_abort(ERR_OVERFLOW);
            else if (c.write_fail) model_abort(ERR_WRITE);
            else begin
              st_received    = sum[SizeW-1:0];
              st_since_chunk = '0;
              st_crc_acc     = st_crc_acc ^ ~st_chunk_crc;
              st_chunk_crc   = CrcInit;
              st_percent = (st_total == '0) ? '0 :
                           PctW'((64'(st_received) * 64'd100) / 64'(st_total));
              if (st_received >= st_total) model_verify(c.finish_fail);
            end
          end
        end
      end
      OP_TICK: begin
        if (st_since_start != TimerMax) st_since_start = st_since_start + 1'b1;
        if (st_since_chunk != TimerMax) st_since_chunk = st_since_chunk + 1'b1;
        if (st_fsm != SES_IDLE && st_fsm != SES_ERROR && st_since_start > cfg_global_to)
          model_abort(ERR_GLOBAL_TO);
        else if (st_fsm == SES_WAITING && st_since_start > cfg_waiting_to)
          model_abort(ERR_WAITING_TO);
        else if (st_fsm == SES_RECEIVING && st_since_chunk > cfg_chunk_to)
          model_abort(ERR_CHUNK_TO);
      end
      default: ;
    endcase
    // chunk accumulator only lives in waiting and receiving
    if (st_fsm != SES_WAITING && st_fsm != SES_RECEIVING) begin
      st_chunk_crc = CrcInit;
      st_chunk_len = '0;
    end
    r.session_state    = st_fsm;
    r.error_code       = st_err;
    r.received_bytes   = st_received;
    r.total_bytes      = st_total;
    r.progress_percent = st_percent;
    r.image_crc        = st_crc_acc;
    return r;
  endfunction

  // ------------------------------------------------------------ stimulus
  function automatic iurc_in_t rand_cmd(input logic [OpW-1:0] op);
    iurc_in_t c;
    c.op          = op;
    c.size        = SizeW'($urandom);
    c.data_byte   = ByteW'($urandom);
    c.chunk_last  = 1'($urandom);
    c.begin_fail  = 1'($urandom);
    c.write_fail  = 1'($urandom);
    c.finish_fail = 1'($urandom);
    return c;
  endfunction

  task automatic push_cmd(input logic [OpW-1:0] op, input logic [SizeW-1:0] size,
                          input logic [ByteW-1:0] b, input logic last,
                          input logic bf, input logic wf, input logic ff);
    iurc_in_t c;
    c.op          = op;
    c.size        = size;
    c.data_byte   = b;
    c.chunk_last  = last;
    c.begin_fail  = bf;
    c.write_fail  = wf;
    c.finish_fail = ff;
    cmd_q.push_back(c);
  endtask

  // One well-formed session with random content, ticks and occasional faults
  task automatic queue_session(input int unsigned max_len);
    iurc_in_t    c;
    int unsigned total;
    int unsigned sent;
    int unsigned clen;
    int unsigned room;
    total = $urandom_range(max_len, 1);
    c = rand_cmd(OP_START);
    c.size = SizeW'(total);
    c.begin_fail = ($urandom_range(19, 0) == 0);
    cmd_q.push_back(c);
    repeat ($urandom_range(3, 0)) cmd_q.push_back(rand_cmd(OP_TICK));
    sent = 0;
    while (sent < total) begin
      room = total - sent;
      clen = $urandom_range((room < 12) ? room : 12, 1);
      // now and then a chunk that runs past the announced size
      if ($urandom_range(11, 0) == 0) clen = room + $urandom_range(3, 1);
      for (int i = 0; i < clen; i++) begin
        c = rand_cmd(OP_DATA);
        c.chunk_last  = (i == clen - 1);
        c.write_fail  = ($urandom_range(24, 0) == 0);
        c.finish_fail = ($urandom_range(7, 0) == 0);
        cmd_q.push_back(c);
        if ($urandom_range(7, 0) == 0) cmd_q.push_back(rand_cmd(OP_TICK));
      end
      sent += clen;
      repeat ($urandom_range(3, 0)) cmd_q.push_back(rand_cmd(OP_TICK));
      if ($urandom_range(29, 0) == 0) begin
        cmd_q.push_back(rand_cmd(OP_ABORT));
        sent = total;
      end else if ($urandom_range(24, 0) == 0) begin
        cmd_q.push_back(rand_cmd(OP_VERIFY));
        sent = total;
      end
    end
    case ($urandom_range(3, 0))
      0:       cmd_q.push_back(rand_cmd(OP_VERIFY));
      1:       cmd_q.push_back(rand_cmd(OP_START));
      2:       cmd_q.push_back(rand_cmd(OP_ABORT));
      default: ;
    endcase
  endtask

  // Mostly sessions, some fully random commands
  task automatic fill_random(input int unsigned n, input int unsigned max_len);
    iurc_in_t    c;
    int unsigned goal;
    goal = cmd_q.size() + n;
    while (cmd_q.size() < goal) begin
      if ($urandom_range(9, 0) == 0) begin
        c = rand_cmd(OpW'($urandom_range(7, 0)));
        if ($urandom_range(1, 0) == 1) c.size = SizeW'($urandom_range(40, 1));
        cmd_q.push_back(c);
      end else begin
        queue_session(max_len);
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MAX_IMAGE:  cfg_max_image  = data[SizeW-1:0];
      CFG_GLOBAL_TO:  cfg_global_to  = data[TimerW-1:0];
      CFG_WAITING_TO: cfg_waiting_to = data[TimerW-1:0];
      CFG_CHUNK_TO:   cfg_chunk_to   = data[TimerW-1:0];
      default: ;
    endcase
  endtask

  // timer value with junk in the unused upper bits
  function automatic logic [CfgW-1:0] timer_word(input logic [TimerW-1:0] v);
    return {(CfgW-TimerW)'($urandom), v};
  endfunction

  task automatic set_pace(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= stall_pct;
  endtask

  task automatic wait_drain();
    while (cmd_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt < 100)
      $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // -------------------------------------------------------------- driver
  always @(posedge clk_i) begin
    logic take;
    if (rst_ni) begin
      take = in_valid && !in_stall;
      if (take) status_q.push_back(session_step(in_item));
      if (!in_valid || take) begin
        if (cmd_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_item  <= cmd_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    iurc_out_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          report_mismatch("status item with nothing expected", out_item.session_state, '0);
        end else begin
          want = status_q.pop_front();
          if (out_item.session_state !== want.session_state)
            report_mismatch("session_state", out_item.session_state, want.session_state);
          if (out_item.error_code !== want.error_code)
            report_mismatch("error_code", out_item.error_code, want.error_code);
          if (out_item.received_bytes !== want.received_bytes)
            report_mismatch("received_bytes", out_item.received_bytes, want.received_bytes);
          if (out_item.total_bytes !== want.total_bytes)
            report_mismatch("total_bytes", out_item.total_bytes, want.total_bytes);
          if (out_item.progress_percent !== want.progress_percent)
            report_mismatch("progress_percent", out_item.progress_percent,
                            want.progress_percent);
          if (out_item.image_crc !== want.image_crc)
            report_mismatch("image_crc", out_item.image_crc, want.image_crc);
        end
      end
      out_stall <= hold_on || ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here while the driver keeps offering
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------- test flow
  initial begin
    cfg_max_image  = MaxImageRst;
    cfg_global_to  = GlobalToRst;
    cfg_waiting_to = WaitToRst;
    cfg_chunk_to   = ChunkToRst;
    model_clear();
    st_fsm = SES_IDLE;
    st_err = ERR_NONE;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset defaults, no idling
    push_cmd(OP_VERIFY, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);          // verify while idle
    push_cmd(OP_START, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);           // zero size
    push_cmd(OP_START, SizeW'(MaxImageRst + 1), 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_START, MaxImageRst, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);  // begin failure
    push_cmd(OP_DATA, '0, 8'h5A, 1'b1, 1'b0, 1'b0, 1'b0);            // byte with no session
    push_cmd(OP_START, 24'd3, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_START, 24'd5, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);        // busy
    push_cmd(OP_DATA, '0, 8'h11, 1'b1, 1'b0, 1'b0, 1'b0);            // dropped in error
    push_cmd(OP_ABORT, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_START, 24'd3, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_DATA, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_DATA, '0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_TICK, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_DATA, '0, 8'hA5, 1'b1, 1'b0, 1'b0, 1'b1);            // finish failure
    push_cmd(OP_START, 24'd2, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_DATA, '0, 8'h3C, 1'b1, 1'b0, 1'b1, 1'b0);            // write failure
    push_cmd(OP_START, 24'd2, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_DATA, '0, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_DATA, '0, 8'h80, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_DATA, '0, 8'h7F, 1'b1, 1'b0, 1'b0, 1'b0);            // overflow
    push_cmd(OP_START, MaxImageRst, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);  // largest allowed
    push_cmd(OP_DATA, '0, 8'hC3, 1'b1, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_VERIFY, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);          // early verify: ready
    push_cmd(OP_TICK, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(3'd5, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);               // unused op codes
    push_cmd(3'd7, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_ABORT, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    fill_random(60, 40);
    wait_drain();

    // Short timeouts so all three fire; sender idles
    write_reg(CFG_MAX_IMAGE, CfgW'($urandom_range(1000, 40)));
    write_reg(CFG_GLOBAL_TO, timer_word(TimerW'(30)));
    write_reg(CFG_WAITING_TO, timer_word(TimerW'(2)));
    write_reg(CFG_CHUNK_TO, timer_word(TimerW'(2)));
    set_pace(67, 0);
    fill_random(80, 40);
    wait_drain();

    // Largest image size, zero timeouts; receiver stalls and holds off once
    write_reg(CFG_MAX_IMAGE, {CfgW{1'b1}});
    write_reg(CFG_GLOBAL_TO, timer_word('0));
    write_reg(CFG_WAITING_TO, timer_word('0));
    write_reg(CFG_CHUNK_TO, timer_word('0));
    set_pace(0, 67);
    push_cmd(OP_START, {SizeW{1'b1}}, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_DATA, '0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_DATA, '0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
    push_cmd(OP_TICK, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    fill_random(80, 60);
    hold_go = 1'b1;
    wait_drain();

    // Smallest image size, timeouts disabled; both sides idle
    write_reg(CFG_MAX_IMAGE, CfgW'(1));
    write_reg(CFG_GLOBAL_TO, timer_word(TimerMax));
    write_reg(CFG_WAITING_TO, timer_word(TimerMax));
    write_reg(CFG_CHUNK_TO, timer_word(TimerMax));
    set_pace(37, 37);
    fill_random(60, 1);
    wait_drain();

    // Random settings, no idling
    write_reg(CFG_MAX_IMAGE, CfgW'($urandom_range(24'hFFFFFF, 2000)));
    write_reg(CFG_GLOBAL_TO, timer_word(TimerW'($urandom_range(400, 20))));
    write_reg(CFG_WAITING_TO, timer_word(TimerW'($urandom_range(8, 1))));
    write_reg(CFG_CHUNK_TO, timer_word(TimerW'($urandom_range(8, 1))));
    set_pace(0, 0);
    fill_random(70, 40);
    wait_drain();

    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/iurc_pkg.sv
rtl/core/iurc_div.sv
rtl/core/image_update_receive_controller_core.sv
tb/sv/tb_image_update_receive_controller_core.sv
